FILE: rtl/seven_segment_two_wire_frame_sender_macros.svh
// Assertion macros for the two-wire display frame sender.
// Included by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_TWO_WIRE_FRAME_SENDER_MACROS_SVH
`define SEVEN_SEGMENT_TWO_WIRE_FRAME_SENDER_MACROS_SVH

`ifndef SYNTH
`define SSTW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sstw assertion failed");
`define SSTW_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("sstw assertion failed");
`else
`define SSTW_ASSERT(label, prop)
`define SSTW_ASSERT_NEXT(label, cond, expr)
`endif

`endif

FILE: rtl/sstw_pkg.sv
// Constants, types and font table for the two-wire display frame sender.
// No dependencies.
package sstw_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [7:0] tick_t;

  localparam tick_t FRAME_TICKS = 8'd138;
  localparam tick_t LAST_TICK   = 8'd137;
  localparam tick_t DATA_BASE   = 8'd22;
  localparam tick_t CTRL_BASE   = 8'd116;
  localparam tick_t UNIT_TICKS  = 8'd18;
  localparam tick_t START_TICKS = 8'd2;
  localparam tick_t ONE_UNIT    = 8'd18;
  localparam tick_t FIVE_UNITS  = 8'd90;

  localparam byte_t CMD_DATA = 8'h40;
  localparam byte_t CMD_ADDR = 8'hC0;
  localparam byte_t CMD_CTRL = 8'h88;
  localparam byte_t POINT_BIT = 8'h80;

  localparam logic [2:0] BRIGHT_RESET = 3'd7;

  localparam byte_t SEG_FONT [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  typedef enum logic [1:0] {
    SEG_CMD  = 2'd0,
    SEG_DATA = 2'd1,
    SEG_CTRL = 2'd2
  } seg_kind_t;

endpackage

FILE: rtl/seven_segment_two_wire_frame_sender.sv
// Two-wire seven-segment display frame sender, top level.
// Depends on sstw_pkg and seven_segment_two_wire_frame_sender_macros.svh.
//
// Usage: every input beat is one half-bit timer tick and gives exactly one
// output beat with the clock and data levels for that tick, busy and a
// frame-done mark. A beat with load set while idle latches four hex digits
// and the point flag, and starts a 138-tick frame: data command, address
// command with four segment codes, then display control with brightness.
// The cfg port writes the 3-bit brightness; it is read when the control
// byte is driven.
// The output is registered: the output register holds the result of the beat
// accepted at the previous edge. One beat per cycle is sustained while the
// output is not stalled; the tick sequencer advances one position per beat.
// When the receiver stalls, the output beat holds and the input is stalled
// only while the output register is full and stalled.
// Reset returns the sequencer to idle, empties the output register and sets
// brightness to 7.
`include "seven_segment_two_wire_frame_sender_macros.svh"

module seven_segment_two_wire_frame_sender (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_load,
  input  logic [3:0] in_digit_a,
  input  logic [3:0] in_digit_b,
  input  logic [3:0] in_digit_c,
  input  logic [3:0] in_digit_d,
  input  logic       in_point_on,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_clock_line,
  output logic       out_data_line,
  output logic       out_busy_res,
  output logic       out_frame_done
);
  import sstw_pkg::*;

  logic [2:0] bright_r;
  tick_t      pos_r, pos_nxt;
  logic       active_r, active_nxt;
  byte_t      codes_r [4];
  logic       out_valid_r;
  logic       clk_line_r, data_line_r, busy_r, done_r;

  logic       in_acc, start_w;
  tick_t      p, base, span, r, rr, ubase;
  seg_kind_t  kind;
  logic [2:0] u;
  logic [4:0] q;
  byte_t      cur_byte, pt;
  logic       clk_nxt, data_nxt, done_nxt;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign start_w   = in_acc & ~active_r & in_load;
  assign pt        = in_point_on ? POINT_BIT : 8'h00;
  assign out_valid = out_valid_r;
  assign out_clock_line = clk_line_r;
  assign out_data_line  = data_line_r;
  assign out_busy_res   = busy_r;
  assign out_frame_done = done_r;

  always_comb begin
    if (start_w) begin
      p = '0;
    end else if (pos_r >= FRAME_TICKS) begin
      p = LAST_TICK;
    end else begin
      p = pos_r;
    end

    if (p < DATA_BASE) begin
      kind = SEG_CMD;
      base = '0;
      span = ONE_UNIT;
    end else if (p < CTRL_BASE) begin
      kind = SEG_DATA;
      base = DATA_BASE;
      span = FIVE_UNITS;
    end else begin
      kind = SEG_CTRL;
      base = CTRL_BASE;
      span = ONE_UNIT;
    end

    r  = p - base;
    rr = r - START_TICKS;

    if (rr < UNIT_TICKS) begin
      u = 3'd0;
    end else if (rr < 8'd36) begin
      u = 3'd1;
    end else if (rr < 8'd54) begin
      u = 3'd2;
    end else if (rr < 8'd72) begin
      u = 3'd3;
    end else begin
      u = 3'd4;
    end
    ubase = 8'(u) * UNIT_TICKS;
    q = 5'(rr - ubase);

    case (kind)
      SEG_CMD:  cur_byte = CMD_DATA;
      SEG_CTRL: cur_byte = CMD_CTRL | {5'd0, bright_r};
      SEG_DATA: begin
        if (u == 3'd0) begin
          cur_byte = CMD_ADDR;
        end else begin
          cur_byte = codes_r[2'(u - 3'd1)];
        end
      end
      default:  cur_byte = CMD_DATA;
    endcase

    if (r < START_TICKS) begin
      clk_nxt  = 1'b1;
      data_nxt = (r == 8'd0);
    end else if (rr < span) begin
      clk_nxt  = q[0];
      data_nxt = (q < 5'd16) ? cur_byte[q[3:1]] : cur_byte[7];
    end else begin
      clk_nxt  = (rr != span);
      data_nxt = 1'b0;
    end

    done_nxt = (p == LAST_TICK);
  end

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    if (in_acc && (active_r || start_w)) begin
      if (done_nxt) begin
        pos_nxt    = '0;
        active_nxt = 1'b0;
      end else begin
        pos_nxt    = p + 8'd1;
        active_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= BRIGHT_RESET;
      pos_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bright_r <= cfg_wr_data;
      end
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_w) begin
      codes_r[0] <= SEG_FONT[in_digit_a] | pt;
      codes_r[1] <= SEG_FONT[in_digit_b] | pt;
      codes_r[2] <= SEG_FONT[in_digit_c] | pt;
      codes_r[3] <= SEG_FONT[in_digit_d] | pt;
    end
    if (in_acc) begin
      if (active_r || start_w) begin
        clk_line_r  <= clk_nxt;
        data_line_r <= data_nxt;
        busy_r      <= 1'b1;
        done_r      <= done_nxt;
      end else begin
        clk_line_r  <= 1'b1;
        data_line_r <= 1'b1;
        busy_r      <= 1'b0;
        done_r      <= 1'b0;
      end
    end
  end

  `SSTW_ASSERT(a_pos_range, pos_r < FRAME_TICKS)
  `SSTW_ASSERT(a_idle_pos_zero, !active_r |-> (pos_r == 8'd0))
  `SSTW_ASSERT_NEXT(a_idle_stays, in_acc && !active_r && !in_load, !active_r)
  `SSTW_ASSERT_NEXT(a_done_ends, in_acc && active_r && (pos_r == LAST_TICK),
                    !active_r && out_frame_done && out_busy_res)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for seven_segment_two_wire_frame_sender.
// Drives half-bit ticks and predicts the clock and data levels of every beat.
// Depends on sstw_pkg and the RTL of the frame sender only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sstw_pkg::*;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic busy;
    logic done;
  } line_levels_t;

  typedef struct {
    logic         load;
    logic [3:0]   a;
    logic [3:0]   b;
    logic [3:0]   c;
    logic [3:0]   d;
    logic         pt;
    int           reps;
    bit           typed;
    line_levels_t want;
  } script_row_t;

  localparam line_levels_t LINES_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0};
  localparam line_levels_t LINES_NONE = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam int PHASES = 6;
  localparam int PHASE_TICKS = 100;
  localparam int HOLD_AT = 1200;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_load;
  logic [3:0] in_digit_a;
  logic [3:0] in_digit_b;
  logic [3:0] in_digit_c;
  logic [3:0] in_digit_d;
  logic       in_point_on;
  logic       out_valid;
  logic       out_stall;
  logic       out_clock_line;
  logic       out_data_line;
  logic       out_busy_res;
  logic       out_frame_done;

  seven_segment_two_wire_frame_sender u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_load       (in_load),
    .in_digit_a    (in_digit_a),
    .in_digit_b    (in_digit_b),
    .in_digit_c    (in_digit_c),
    .in_digit_d    (in_digit_d),
    .in_point_on   (in_point_on),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_clock_line(out_clock_line),
    .out_data_line (out_data_line),
    .out_busy_res  (out_busy_res),
    .out_frame_done(out_frame_done)
  );

  always #6 clk = ~clk;

  // Shadow state of the frame sequencer.
  logic [2:0] lamp_level;
  tick_t      frm_pos;
  byte_t      latched_codes [4];
  bit         frm_active;
  logic       lvl_clk;
  logic       lvl_dat;

  line_levels_t pending_levels [$];
  int           mismatches;
  int           beats_checked;
  bit           sender_steady;

  script_row_t demo_rows [18] = '{
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b1, LINES_IDLE},
    '{1'b0, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1, 1'b1, LINES_IDLE},
    '{1'b1, 4'h0, 4'h1, 4'h2, 4'h3, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0}},
    '{1'b1, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 135, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1}},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b1, LINES_IDLE},
    '{1'b1, 4'h4, 4'h5, 4'h6, 4'h7, 1'b1, 1, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 137, 1'b0, LINES_NONE},
    '{1'b1, 4'h8, 4'h9, 4'hA, 4'hB, 1'b0, 1, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 137, 1'b0, LINES_NONE},
    '{1'b1, 4'hC, 4'hD, 4'hE, 4'hF, 1'b1, 1, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 137, 1'b0, LINES_NONE},
    '{1'b1, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1, 1'b0, LINES_NONE},
    '{1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 137, 1'b0, LINES_NONE},
    '{1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 137, 1'b0, LINES_NONE},
    '{1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1, 1'b1, LINES_IDLE}
  };

  function automatic int idle_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic line_levels_t next_line_levels(logic load, logic [3:0] a, logic [3:0] b,
                                                    logic [3:0] c, logic [3:0] d, logic pt);
    line_levels_t lv;
    int           p;
    int           base;
    int           units;
    int           r;
    int           u;
    int           q;
    byte_t        pt_mask;
    byte_t        cur;
    logic         done;
    lv = LINES_IDLE;
    done = 1'b0;
    if (!frm_active && load) begin
      pt_mask = pt ? POINT_BIT : 8'h00;
      latched_codes[0] = SEG_FONT[a] | pt_mask;
      latched_codes[1] = SEG_FONT[b] | pt_mask;
      latched_codes[2] = SEG_FONT[c] | pt_mask;
      latched_codes[3] = SEG_FONT[d] | pt_mask;
      frm_active = 1'b1;
      frm_pos = '0;
    end
    if (frm_active) begin
      p = int'(frm_pos);
      if (p < DATA_BASE) begin
        base = 0;
        units = 1;
      end else if (p < CTRL_BASE) begin
        base = int'(DATA_BASE);
        units = 5;
      end else begin
        base = int'(CTRL_BASE);
        units = 1;
      end
      r = p - base;
      if (r < START_TICKS) begin
        lvl_clk = 1'b1;
        lvl_dat = (r == 0);
      end else begin
        r = r - START_TICKS;
        if (r < units * UNIT_TICKS) begin
          u = r / UNIT_TICKS;
          q = r % UNIT_TICKS;
          lvl_clk = q[0];
          // The ack pulse keeps the data level of the last bit.
          if (q < 16) begin
            if (base == 0) cur = CMD_DATA;
            else if (base == CTRL_BASE) cur = CMD_CTRL | {5'b0, lamp_level};
            else if (u == 0) cur = CMD_ADDR;
            else cur = latched_codes[u - 1];
            lvl_dat = cur[q / 2];
          end
        end else begin
          r = r - units * UNIT_TICKS;
          lvl_clk = (r != 0);
          lvl_dat = 1'b0;
        end
      end
      if (p == LAST_TICK) begin
        done = 1'b1;
        frm_active = 1'b0;
        frm_pos = '0;
      end else begin
        frm_pos = tick_t'(p + 1);
      end
      lv = '{lvl_clk, lvl_dat, 1'b1, done};
    end else begin
      lvl_clk = 1'b1;
      lvl_dat = 1'b1;
    end
    return lv;
  endfunction

  task automatic push_tick(logic load, logic [3:0] a, logic [3:0] b, logic [3:0] c,
                           logic [3:0] d, logic pt, bit typed, line_levels_t want);
    int           gap;
    line_levels_t pred;
    if ($urandom_range(0, 99) == 0) sender_steady = ~sender_steady;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_load <= load;
    in_digit_a <= a;
    in_digit_b <= b;
    in_digit_c <= c;
    in_digit_d <= d;
    in_point_on <= pt;
    pred = next_line_levels(load, a, b, c, d, pt);
    pending_levels.push_back(typed ? want : pred);
    do @(posedge clk); while (in_stall);
  endtask

  // Runs the current frame out and lets every result arrive.
  task automatic settle_frames();
    while (frm_active)
      push_tick(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), 1'b0, LINES_NONE);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_brightness(logic [2:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lamp_level = v;
  endtask

  task automatic flag_field(string what, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %b, got %b", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    line_levels_t exp_lv;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: beat with nothing expected, got clk %b data %b busy %b done %b",
                 $time, out_clock_line, out_data_line, out_busy_res, out_frame_done);
        mismatches++;
      end else begin
        exp_lv = pending_levels.pop_front();
        flag_field("clock_line", exp_lv.clock_line, out_clock_line);
        flag_field("data_line", exp_lv.data_line, out_data_line);
        flag_field("busy_res", exp_lv.busy, out_busy_res);
        flag_field("frame_done", exp_lv.done, out_frame_done);
        beats_checked++;
      end
    end
  end

  initial begin
    int  run;
    bit  quiet;
    bit  held_off;
    run = 0;
    quiet = 1'b0;
    held_off = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && beats_checked >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      if (run > 0) begin
        run--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        run = idle_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [2:0] lamp_plan [4];
    logic       load;
    lamp_plan = '{3'd0, 3'd5, 3'd7, 3'd2};
    mismatches = 0;
    beats_checked = 0;
    sender_steady = 1'b0;
    lamp_level = BRIGHT_RESET;
    frm_pos = '0;
    frm_active = 1'b0;
    lvl_clk = 1'b1;
    lvl_dat = 1'b1;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_load = 1'b0;
    in_digit_a = '0;
    in_digit_b = '0;
    in_digit_c = '0;
    in_digit_d = '0;
    in_point_on = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (demo_rows[i])
      repeat (demo_rows[i].reps)
        push_tick(demo_rows[i].load, demo_rows[i].a, demo_rows[i].b, demo_rows[i].c,
                  demo_rows[i].d, demo_rows[i].pt, demo_rows[i].typed, demo_rows[i].want);
    settle_frames();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_brightness(ph < 4 ? lamp_plan[ph] : 3'($urandom_range(0, 7)));
      repeat (PHASE_TICKS) begin
        load = frm_active ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) != 0);
        push_tick(load, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'b0, LINES_NONE);
      end
      settle_frames();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sstw_pkg.sv
rtl/seven_segment_two_wire_frame_sender.sv
tb/tb.sv
